FILE: rtl/core/anp_pkg.sv
// shared types, constants and helper functions for the ascii number parser
// no dependencies; used by anp_step and ascii_number_parser_core
package anp_pkg;

    localparam int DEFAULT_MAX_HEX_DIGITS = 8;

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 32;
    localparam int DIGIT_W = 4;

    localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_DOLLAR  = 8'h24;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_X_LOWER = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_A_LOWER = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_F_LOWER = 8'h66;
    localparam logic [CHAR_W-1:0] CHAR_A_UPPER = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_F_UPPER = 8'h46;
    localparam logic [CHAR_W-1:0] HEX_LOWER_OFS = 8'd87;
    localparam logic [CHAR_W-1:0] HEX_UPPER_OFS = 8'd55;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_ZERO  = 2'd1,
        PH_DEC   = 2'd2,
        PH_HEX   = 2'd3
    } anp_phase_t;

    // parse state that does not depend on the hex digit limit
    typedef struct packed {
        anp_phase_t         phase;
        logic [VALUE_W-1:0] acc;
        logic               error;
    } anp_core_t;

    function automatic logic is_dec_digit(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // digit value in the low four bits, bit 4 set when not a hex digit
    function automatic logic [DIGIT_W:0] hex_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] diff;
        diff = 8'd0;
        if (is_dec_digit(c)) begin
            diff = c - CHAR_ZERO;
            return {1'b0, diff[DIGIT_W-1:0]};
        end
        if ((c >= CHAR_A_LOWER) && (c <= CHAR_F_LOWER)) begin
            diff = c - HEX_LOWER_OFS;
            return {1'b0, diff[DIGIT_W-1:0]};
        end
        if ((c >= CHAR_A_UPPER) && (c <= CHAR_F_UPPER)) begin
            diff = c - HEX_UPPER_OFS;
            return {1'b0, diff[DIGIT_W-1:0]};
        end
        return {1'b1, {DIGIT_W{1'b0}}};
    endfunction

endpackage

FILE: rtl/core/anp_step.sv
// next parse state for one non-terminator character
// depends on anp_pkg
module anp_step #(
    parameter int MAX_HEX_DIGITS = anp_pkg::DEFAULT_MAX_HEX_DIGITS,
    parameter int CNT_W          = $clog2(MAX_HEX_DIGITS + 1)
) (
    input  logic [anp_pkg::CHAR_W-1:0] character,
    input  anp_pkg::anp_core_t         cur,
    input  logic [CNT_W-1:0]           cnt,
    output anp_pkg::anp_core_t         nxt,
    output logic [CNT_W-1:0]           cnt_next
);

    logic                                dec_ok;
    logic [anp_pkg::VALUE_W-1:0]         dec_acc;
    logic [anp_pkg::DIGIT_W:0]           hex_d;
    logic                                hex_full;
    logic [anp_pkg::CHAR_W-1:0]          dec_diff;

    // acc * 10 + digit as two shifts and adds
    assign dec_ok   = anp_pkg::is_dec_digit(character);
    assign dec_diff = character - anp_pkg::CHAR_ZERO;
    assign dec_acc  = {cur.acc[anp_pkg::VALUE_W-4:0], 3'b000}
                    + {cur.acc[anp_pkg::VALUE_W-2:0], 1'b0}
                    + {{(anp_pkg::VALUE_W-anp_pkg::DIGIT_W){1'b0}},
                       dec_diff[anp_pkg::DIGIT_W-1:0]};
    assign hex_d    = anp_pkg::hex_value(character);
    assign hex_full = cnt >= CNT_W'(MAX_HEX_DIGITS);

    // phase transitions, accumulator, digit count and error flag
    always_comb
    begin
        nxt      = cur;
        cnt_next = cnt;
        if (!cur.error)
        begin
            unique case (cur.phase)
                anp_pkg::PH_START:
                begin
                    if (character == anp_pkg::CHAR_DOLLAR)
                        nxt.phase = anp_pkg::PH_HEX;
                    else if (character == anp_pkg::CHAR_ZERO)
                    begin
                        nxt.phase = anp_pkg::PH_ZERO;
                        nxt.acc   = '0;
                    end
                    else
                    begin
                        nxt.phase = anp_pkg::PH_DEC;
                        if (dec_ok)
                            nxt.acc = dec_acc;
                        else
                            nxt.error = 1'b1;
                    end
                end
                anp_pkg::PH_ZERO:
                begin
                    if (character == anp_pkg::CHAR_X_LOWER)
                    begin
                        nxt.phase = anp_pkg::PH_HEX;
                        nxt.acc   = '0;
                    end
                    else
                    begin
                        nxt.phase = anp_pkg::PH_DEC;
                        if (dec_ok)
                            nxt.acc = dec_acc;
                        else
                            nxt.error = 1'b1;
                    end
                end
                anp_pkg::PH_HEX:
                begin
                    if (hex_full || hex_d[anp_pkg::DIGIT_W])
                        nxt.error = 1'b1;
                    else
                    begin
                        nxt.acc  = {cur.acc[anp_pkg::VALUE_W-anp_pkg::DIGIT_W-1:0],
                                    hex_d[anp_pkg::DIGIT_W-1:0]};
                        cnt_next = cnt + CNT_W'(1);
                    end
                end
                default:
                begin
                    nxt.phase = anp_pkg::PH_DEC;
                    if (dec_ok)
                        nxt.acc = dec_acc;
                    else
                        nxt.error = 1'b1;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/ascii_number_parser_core.sv
// ascii number parser: one character per request in, one number per string out
// result path: an accepted terminator passes the input register, then sets the result register and m_tvalid
// throughput: one character per cycle while no terminator stalls; set by the combinational parse step
// a terminator stalls only while the result register is full and not taken
// reset (rst_n low, async): parser back at start of string, both registers empty
// depends on anp_pkg and anp_step
module ascii_number_parser_core #(
    parameter int MAX_HEX_DIGITS = anp_pkg::DEFAULT_MAX_HEX_DIGITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // character stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [anp_pkg::CHAR_W-1:0]    s_tdata,   // [7:0] character
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [anp_pkg::VALUE_W-1:0]   m_tdata,   // [31:0] value
    output logic                          m_tuser    // [0] rejected
);

    localparam int CNT_W = $clog2(MAX_HEX_DIGITS + 1);

    // input register
    logic                        in_valid_reg, in_valid_next;
    logic [anp_pkg::CHAR_W-1:0]  in_char_reg;

    // parse state
    anp_pkg::anp_core_t          core_reg, core_next, core_step;
    logic [CNT_W-1:0]            cnt_reg, cnt_next, cnt_step;

    // result register
    logic                        out_valid_reg, out_valid_next;
    logic [anp_pkg::VALUE_W-1:0] out_value_reg;
    logic                        out_rejected_reg;

    logic is_term;
    logic out_free;
    logic proc_fire;
    logic term_fire;
    logic in_take;

    assign is_term   = in_char_reg == anp_pkg::CHAR_NUL;
    assign out_free  = !out_valid_reg || m_tready;
    // a terminator needs room in the result register, other characters never wait
    assign proc_fire = in_valid_reg && (!is_term || out_free);
    assign term_fire = proc_fire && is_term;
    assign s_tready  = !in_valid_reg || proc_fire;
    assign in_take   = s_tvalid && s_tready;

    anp_step #(
        .MAX_HEX_DIGITS (MAX_HEX_DIGITS),
        .CNT_W          (CNT_W)
    ) u_step (
        .character (in_char_reg),
        .cur       (core_reg),
        .cnt       (cnt_reg),
        .nxt       (core_step),
        .cnt_next  (cnt_step)
    );

    // parse state update; the terminator restarts the string
    always_comb
    begin
        core_next = core_reg;
        cnt_next  = cnt_reg;
        if (term_fire)
        begin
            core_next.phase = anp_pkg::PH_START;
            core_next.acc   = '0;
            core_next.error = 1'b0;
            cnt_next        = '0;
        end
        else if (proc_fire)
        begin
            core_next = core_step;
            cnt_next  = cnt_step;
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (proc_fire)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (term_fire)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            core_reg.phase  <= anp_pkg::PH_START;
            core_reg.acc    <= '0;
            core_reg.error  <= 1'b0;
            cnt_reg         <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            core_reg      <= core_next;
            cnt_reg       <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_char_reg <= s_tdata;
        if (term_fire)
        begin
            // rejected strings report zero
            out_value_reg    <= core_reg.error ? '0 : core_reg.acc;
            out_rejected_reg <= core_reg.error;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_rejected_reg;

endmodule

FILE: tb/ascii_number_parser_core_checker.sv
// checker for the ascii number parser: watches both streams, predicts, compares
// depends on anp_pkg; instantiated beside the block by ascii_number_parser_core_tb
`timescale 1ns / 1ps

module ascii_number_parser_core_checker
    import anp_pkg::*;
#(
    parameter int MAX_HEX_DIGITS = anp_pkg::DEFAULT_MAX_HEX_DIGITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [CHAR_W-1:0]  s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [VALUE_W-1:0] m_tdata,
    input  logic               m_tuser,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               rejected;
    } parsed_number_t;

    parsed_number_t numbers_q[$];

    anp_phase_t         phase = PH_START;
    logic [VALUE_W-1:0] acc = '0;
    int                 hex_count = 0;
    logic               bad_seen = 1'b0;
    int                 mismatches = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic clear_parse();
        phase     = PH_START;
        acc       = '0;
        hex_count = 0;
        bad_seen  = 1'b0;
    endtask

    // digit value in [3:0], bit 4 set for a non-hex character
    function automatic logic [4:0] hex_digit_of(input logic [CHAR_W-1:0] c);
        logic [4:0] d;
        if (c >= 8'h30 && c <= 8'h39)
            d = {1'b0, c[3:0]};
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            d = {1'b0, c[3:0] + 4'd9};
        else
            d = 5'b10000;
        return d;
    endfunction

    task automatic add_decimal(input logic [CHAR_W-1:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
            acc = acc * 32'd10 + VALUE_W'(c - CHAR_ZERO);
        else
            bad_seen = 1'b1;
    endtask

    task automatic parse_char(input logic [CHAR_W-1:0] c);
        parsed_number_t r;
        logic [4:0]     d;
        if (c == CHAR_NUL)
        begin
            r.value    = bad_seen ? '0 : acc;
            r.rejected = bad_seen;
            numbers_q.push_back(r);
            clear_parse();
        end
        else if (!bad_seen)
        begin
            case (phase)
                PH_START:
                    if (c == CHAR_DOLLAR)
                        phase = PH_HEX;
                    else if (c == CHAR_ZERO)
                    begin
                        phase = PH_ZERO;
                        acc   = '0;
                    end
                    else
                    begin
                        phase = PH_DEC;
                        add_decimal(c);
                    end
                PH_ZERO:
                    if (c == CHAR_X_LOWER)
                    begin
                        phase = PH_HEX;
                        acc   = '0;
                    end
                    else
                    begin
                        phase = PH_DEC;
                        add_decimal(c);
                    end
                PH_HEX:
                begin
                    d = hex_digit_of(c);
                    if (hex_count >= MAX_HEX_DIGITS || d[4])
                        bad_seen = 1'b1;
                    else
                    begin
                        acc = {acc[VALUE_W-5:0], d[3:0]};
                        hex_count++;
                    end
                end
                default:
                begin
                    phase = PH_DEC;
                    add_decimal(c);
                end
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        parsed_number_t want;
        if (!rst_n)
        begin
            clear_parse();
            numbers_q.delete();
            pending <= 0;
        end
        else
        begin
            // a result can never leave in the cycle its terminator enters
            if (m_tvalid && m_tready)
            begin
                if (numbers_q.size() == 0)
                    report_mismatch($sformatf("unexpected result value %h rejected %b",
                                              m_tdata, m_tuser));
                else
                begin
                    want = numbers_q.pop_front();
                    if (m_tdata !== want.value)
                        report_mismatch($sformatf("value %h, expected %h",
                                                  m_tdata, want.value));
                    if (m_tuser !== want.rejected)
                        report_mismatch($sformatf("rejected %b, expected %b",
                                                  m_tuser, want.rejected));
                end
            end
            if (s_tvalid && s_tready)
                parse_char(s_tdata);
            pending <= numbers_q.size();
        end
    end

endmodule

FILE: tb/ascii_number_parser_core_tb.sv
// testbench top for ascii_number_parser_core: clock, reset, character and
// ready stimulus, watchdog and verdict; depends on anp_pkg and the checker
`timescale 1ns / 1ps

module ascii_number_parser_core_tb;

    import anp_pkg::*;

    localparam int TOTAL_CHARS    = 850;   // minimum character requests in the whole run
    localparam int QUIET_TAIL     = 100;   // last requests go without idling
    localparam int LONG_HOLD      = 120;   // receiver hold-off, in cycles
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with neither stream handshaking
    localparam int DRAIN_CYCLES   = 10;    // well past the result latency

    // every legal hex digit, both cases
    localparam string HEX_CHARS = "0123456789abcdefABCDEF";

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [CHAR_W-1:0]  s_tdata;    // [7:0] character
    logic               m_tvalid;
    logic               m_tready;
    logic [VALUE_W-1:0] m_tdata;    // [31:0] value
    logic               m_tuser;    // [0] rejected

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int chars_sent  = 0;

    logic [CHAR_W-1:0] text_q[$];   // string being built, terminator not included

    // handshakes between the sender and the receiver processes
    bit quiet         = 1'b0;
    bit hold_off_req  = 1'b0;
    bit holding       = 1'b0;

    ascii_number_parser_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ascii_number_parser_core_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one character request; returns at the edge where it was accepted
    task automatic send_char(input logic [CHAR_W-1:0] c);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        chars_sent++;
    endtask

    // the built string plus its terminator, with random gaps in between
    task automatic send_text();
        int i;
        for (i = 0; i <= text_q.size(); i++)
        begin
            send_char(i < text_q.size() ? text_q[i] : CHAR_NUL);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
        end
    endtask

    task automatic send_literal(input string s);
        int i;
        text_q.delete();
        for (i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
        send_text();
    endtask

    // mostly well-formed hex and decimal strings, some corrupted, some noise
    task automatic build_string();
        int kind;
        int n;
        int i;
        text_q.delete();
        kind = $urandom_range(0, 9);
        if (kind <= 3)
        begin
            // hex: either prefix, digit count mostly within the limit
            if ($urandom_range(0, 1))
                text_q.push_back(CHAR_DOLLAR);
            else
            begin
                text_q.push_back(CHAR_ZERO);
                text_q.push_back(CHAR_X_LOWER);
            end
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 8);
            for (i = 0; i < n; i++)
                text_q.push_back(HEX_CHARS[$urandom_range(0, 21)]);
        end
        else if (kind <= 7)
        begin
            // decimal, long enough to wrap past 32 bits at times
            n = $urandom_range(1, 12);
            for (i = 0; i < n; i++)
                text_q.push_back(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
        end
        else if (kind == 8)
        begin
            // noise over the whole non-zero byte range
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
                text_q.push_back(CHAR_W'($urandom_range(1, 255)));
        end
        else
        begin
            // empty, bare prefixes and the upper case x form
            case ($urandom_range(0, 3))
                0: ;
                1: text_q.push_back(CHAR_DOLLAR);
                2:
                begin
                    text_q.push_back(CHAR_ZERO);
                    text_q.push_back(CHAR_X_LOWER);
                end
                default:
                begin
                    text_q.push_back(CHAR_ZERO);
                    text_q.push_back("X");
                    text_q.push_back(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
                end
            endcase
        end
        // corrupt one in four hex and decimal strings with a random byte
        if ((kind == 3 || kind == 7) && text_q.size() > 0)
            text_q[$urandom_range(0, text_q.size() - 1)] = CHAR_W'($urandom_range(1, 255));
    endtask

    // receiver: ready stretches, stall bursts, and one long hold-off on request
    initial
    begin
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                holding      = 1'b1;
                m_tready    <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holding      = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // watchdog: too long with neither stream moving ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("ascii_number_parser_core_tb: FAIL");
                $finish;
            end
        end
    end

    // sender and verdict
    initial
    begin
        int i;
        bit held;
        bit drained;
        held     = 1'b0;
        drained  = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= CHAR_NUL;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty, bare prefixes, lone zero, upper case x,
        // a byte above 127, and hex digits at both ends of both cases
        send_literal("");
        send_literal("$");
        send_literal("0x");
        send_literal("0");
        send_literal("0X1");
        send_literal("\377");
        send_literal("$fFaA0019");

        while (chars_sent < TOTAL_CHARS)
        begin
            if (!held && chars_sent >= TOTAL_CHARS / 3)
            begin
                // long receiver hold-off while short strings keep coming,
                // so both registers fill and the input stalls
                held         = 1'b1;
                hold_off_req = 1'b1;
                s_tvalid    <= 1'b0;
                while (!holding)
                    @(posedge clk);
                for (i = 0; i < 12; i++)
                begin
                    text_q.delete();
                    if (i % 2)
                        text_q.push_back(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
                    send_text();
                end
            end
            if (!drained && chars_sent >= 2 * TOTAL_CHARS / 3)
            begin
                // sender pause until every result has come out
                drained  = 1'b1;
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            if (chars_sent >= TOTAL_CHARS - QUIET_TAIL)
                quiet = 1'b1;
            build_string();
            send_text();
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("ascii_number_parser_core_tb: PASS");
        else
            $display("ascii_number_parser_core_tb: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/anp_pkg.sv
rtl/core/anp_step.sv
rtl/core/ascii_number_parser_core.sv
tb/ascii_number_parser_core_checker.sv
tb/ascii_number_parser_core_tb.sv
